// ===== rtl/saane_pkg.sv =====
// ----------------------------------------------------------------------------
// saane_pkg
// Shared types, command codes and AES-128 helper functions for the
// NAL unit encryptor.
// ----------------------------------------------------------------------------
package saane_pkg;

	// command codes passed from front to back
	typedef logic [1:0] cmd_kind_t;
	localparam cmd_kind_t CMD_START = 2'd0;
	localparam cmd_kind_t CMD_RAW   = 2'd1;
	localparam cmd_kind_t CMD_ESC   = 2'd2;
	localparam cmd_kind_t CMD_BLOCK = 2'd3;

	// single bytes travel in the top byte of data
	typedef struct packed {
		cmd_kind_t    kind;
		logic [127:0] data;
	} cmd_t;

	// configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t REG_KEY_HIGH = 2'd0;
	localparam cfg_idx_t REG_KEY_LOW  = 2'd1;
	localparam cfg_idx_t REG_IV_HIGH  = 2'd2;
	localparam cfg_idx_t REG_IV_LOW   = 2'd3;

	localparam logic [7:0] PREVENTION_BYTE = 8'h03;
	localparam int unsigned MIN_ENC_LEN    = 48;
	localparam int unsigned FIRST_BLOCK    = 32;
	localparam int unsigned BLOCK_STRIDE   = 160;
	localparam int unsigned BLOCK_BYTES    = 16;
	localparam logic [4:0]  TYPE_SLICE     = 5'd1;
	localparam logic [4:0]  TYPE_IDR       = 5'd5;
	localparam logic [3:0]  LAST_ROUND     = 4'd10;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of a block sits at bits 127-8i down
	function automatic logic [7:0] get_byte(input logic [127:0] s, input int unsigned i);
		return s[127 - 8 * i -: 8];
	endfunction

	// next round key from the current one
	function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
		logic [31:0] w0, w1, w2, w3, t;
		w3 = rk[31:0];
		t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = rk[127:96] ^ t;
		w1 = rk[95:64] ^ w0;
		w2 = rk[63:32] ^ w1;
		w3 = rk[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// one cipher round; mix column step left out on the last round
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
		input logic mix);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] r;
		r = '0;
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				t[j + 4 * c] = SBOX[get_byte(s, j + 4 * ((c + j) % 4))];
			end
		end
		if (mix) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4 * c];
				a1 = t[4 * c + 1];
				a2 = t[4 * c + 2];
				a3 = t[4 * c + 3];
				t[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
				t[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
				t[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
				t[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[127 - 8 * i -: 8] = t[i];
		end
		return r ^ rk;
	endfunction

endpackage

// ===== rtl/saane_front.sv =====
// ----------------------------------------------------------------------------
// saane_front
// Accepts input transactions, tracks unit offsets and block positions,
// gathers block bytes and issues commands to the back end.
// ----------------------------------------------------------------------------
module saane_front #(
	parameter int OFFSET_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [4:0]        nal_type,
	input  logic [31:0]       unit_length,
	input  logic [7:0]        data_byte,
	output logic              cmd_push,
	output saane_pkg::cmd_t   cmd,
	input  logic              cmd_full
);

	localparam logic [OFFSET_BITS-1:0] NO_BLOCK = '1;

	logic                   encrypting_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [OFFSET_BITS-1:0] next_blk_q;
	logic [OFFSET_BITS-1:0] limit_q;
	logic [3:0]             fill_q;
	logic [119:0]           gather_q;
	logic                   accept;
	logic                   is_enc_type;
	logic                   in_block;
	logic [OFFSET_BITS:0]   nxt;

	assign in_ready = !cmd_full;
	assign accept   = in_valid && in_ready;

	assign is_enc_type = (nal_type == saane_pkg::TYPE_SLICE) ||
		(nal_type == saane_pkg::TYPE_IDR);
	assign in_block = encrypting_q && (next_blk_q != NO_BLOCK) && (offset_q >= next_blk_q);
	assign nxt = {1'b0, next_blk_q} + (OFFSET_BITS+1)'(saane_pkg::BLOCK_STRIDE);

	// command selection
	always_comb begin
		cmd.kind = saane_pkg::CMD_START;
		cmd.data = {data_byte, 120'd0};
		cmd_push = 1'b0;
		if (accept) begin
			if (!action) begin
				cmd_push = 1'b1;
			end else if (!encrypting_q) begin
				cmd.kind = saane_pkg::CMD_RAW;
				cmd_push = 1'b1;
			end else if (!in_block) begin
				cmd.kind = saane_pkg::CMD_ESC;
				cmd_push = 1'b1;
			end else begin
				cmd.kind = saane_pkg::CMD_BLOCK;
				cmd.data = {gather_q, data_byte};
				cmd_push = (fill_q == 4'd15);
			end
		end
	end

	// block gathering shift register
	always_ff @(posedge clk) begin
		if (accept && action && in_block) begin
			gather_q <= {gather_q[111:0], data_byte};
		end
	end

	// unit tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encrypting_q <= 1'b0;
			offset_q     <= '0;
			next_blk_q   <= '0;
			limit_q      <= '0;
			fill_q       <= '0;
		end else if (accept) begin
			if (!action) begin
				fill_q <= '0;
				if (is_enc_type && (unit_length > 32'(saane_pkg::MIN_ENC_LEN))) begin
					encrypting_q <= 1'b1;
					offset_q     <= '0;
					next_blk_q   <= OFFSET_BITS'(saane_pkg::FIRST_BLOCK);
					limit_q      <= OFFSET_BITS'(unit_length - 32'(saane_pkg::BLOCK_BYTES));
				end else begin
					encrypting_q <= 1'b0;
				end
			end else begin
				if (in_block) begin
					fill_q <= fill_q + 4'd1;
					if (fill_q == 4'd15) begin
						next_blk_q <= (nxt >= {1'b0, limit_q}) ? NO_BLOCK
							: nxt[OFFSET_BITS-1:0];
					end
				end
				if (encrypting_q && (offset_q != NO_BLOCK)) begin
					offset_q <= offset_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/saane_queue.sv =====
// ----------------------------------------------------------------------------
// saane_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module saane_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  saane_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output saane_pkg::cmd_t head
);

	saane_pkg::cmd_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty))
		else $error("command queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("command queue count out of range");

endmodule

// ===== rtl/saane_back.sv =====
// ----------------------------------------------------------------------------
// saane_back
// Executes commands: reloads the chain, runs the iterative AES-128 core
// one round per cycle and streams bytes out with emulation prevention.
// ----------------------------------------------------------------------------
module saane_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  saane_pkg::cmd_t cmd,
	output logic            cmd_pop,
	input  logic [127:0]    key,
	input  logic [127:0]    iv,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            is_prevention,
	output logic            last_of_run
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_AES  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]   state_q;
	logic [1:0]   zc_q;
	logic [127:0] chain_q;
	logic [127:0] buf_q;
	logic [127:0] rk_q;
	logic [7:0]   rcon_q;
	logic [3:0]   round_q;
	logic [3:0]   idx_q;
	logic [3:0]   last_idx_q;
	logic         esc_q;
	logic         pre_done_q;
	logic         out_valid_q;
	logic [7:0]   out_byte_q;
	logic         prev_q;
	logic         last_q;

	logic [127:0] rk_n;
	logic [127:0] round_out;
	logic [7:0]   cur;
	logic         out_free;
	logic         insert;

	assign rk_n      = saane_pkg::key_next(rk_q, rcon_q);
	assign round_out = saane_pkg::aes_round(buf_q, rk_n, round_q != saane_pkg::LAST_ROUND);
	assign cur       = buf_q[127:120];
	assign out_free  = !out_valid_q || out_ready;
	assign insert    = esc_q && (zc_q == 2'd2) && (cur[7:2] == 6'd0) && !pre_done_q;
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign is_prevention = prev_q;
	assign last_of_run   = last_q;

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == saane_pkg::CMD_BLOCK) begin
						buf_q   <= cmd.data ^ chain_q ^ key;
						rk_q    <= key;
						rcon_q  <= 8'h01;
						round_q <= 4'd1;
					end else begin
						buf_q <= cmd.data;
					end
					idx_q      <= '0;
					last_idx_q <= '0;
					esc_q      <= (cmd.kind == saane_pkg::CMD_ESC);
					pre_done_q <= 1'b0;
				end
			end
			ST_AES: begin
				buf_q   <= round_out;
				rk_q    <= rk_n;
				rcon_q  <= saane_pkg::xtime(rcon_q);
				round_q <= round_q + 4'd1;
				if (round_q == saane_pkg::LAST_ROUND) begin
					idx_q      <= '0;
					last_idx_q <= 4'd15;
					esc_q      <= 1'b1;
					pre_done_q <= 1'b0;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					if (insert) begin
						pre_done_q <= 1'b1;
					end else begin
						buf_q      <= {buf_q[119:0], 8'h00};
						idx_q      <= idx_q + 4'd1;
						pre_done_q <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			out_byte_q <= insert ? saane_pkg::PREVENTION_BYTE : cur;
			prev_q     <= insert;
			last_q     <= !insert && (idx_q == last_idx_q);
		end
	end

	// control: sequencer, zero run, chain and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			zc_q        <= '0;
			chain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							saane_pkg::CMD_START: begin
								chain_q <= iv;
								zc_q    <= '0;
							end
							saane_pkg::CMD_BLOCK: state_q <= ST_AES;
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_AES: begin
					if (round_q == saane_pkg::LAST_ROUND) begin
						chain_q <= round_out;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (!insert) begin
							if (esc_q) begin
								zc_q <= (cur != 8'h00) ? 2'd0
									: ((zc_q == 2'd2) ? 2'd1 : zc_q + 2'd1);
							end
							if (idx_q == last_idx_q) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_prev_is_03: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && prev_q |-> (out_byte_q == saane_pkg::PREVENTION_BYTE) && !last_q)
		else $error("prevention byte malformed");
	a_zero_run: assert property (@(posedge clk) disable iff (!arst_n)
		zc_q != 2'd3)
		else $error("zero run counter out of range");
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AES) |-> (round_q >= 4'd1) && (round_q <= saane_pkg::LAST_ROUND))
		else $error("cipher round out of range");
	a_insert_then_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && out_free && insert |=> (state_q == ST_EMIT) && pre_done_q)
		else $error("prevention byte not followed by its data byte");

endmodule

// ===== rtl/sample_aes_avc_nal_encryptor.sv =====
// ----------------------------------------------------------------------------
// sample_aes_avc_nal_encryptor
// Sample-AES style encryptor for H.264 NAL unit bodies with emulation
// prevention on the output byte stream.
// ----------------------------------------------------------------------------
// Usage:
//  - configuration: write key and IV through cfg_we/cfg_index/cfg_data
//    while the block is idle; each write takes effect at once.
//  - input channel (in_valid/in_ready): a start transaction (action 0)
//    opens a unit, body transactions (action 1) carry one byte each.
//  - output channel (out_valid/out_ready): one byte per transaction,
//    last_of_run marks the last byte caused by an input transaction.
//  - a plain byte passes through the command queue and the back-end
//    sequencer's fetch (idle) and emit states into the output register;
//    the back end fetches the next command only when it is back to idle.
//    An inserted 0x03 takes an extra emit step ahead of its data byte.
//  - the 16th byte of an encrypted block starts the iterative AES core,
//    one round per cycle; the 16 cipher bytes then go out with any
//    prevention bytes that the escaping inserts. A two-entry command
//    queue lets the front keep accepting while the back end is busy or the
//    receiver stalls; the output register holds its byte until taken.
//  - reset clears key, IV, chain, unit tracking, queue pointers, sequencer state and output valid; no clearing pass.
// ----------------------------------------------------------------------------
module sample_aes_avc_nal_encryptor #(
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [4:0]  nal_type,
	input  logic [31:0] unit_length,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        is_prevention,
	output logic        last_of_run
);

	logic [63:0]     key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic            cmd_push;
	saane_pkg::cmd_t push_cmd;
	logic            cmd_full;
	logic            cmd_pop;
	logic            cmd_valid;
	saane_pkg::cmd_t head_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				saane_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				saane_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				saane_pkg::REG_IV_HIGH:  iv_high_q  <= cfg_data;
				saane_pkg::REG_IV_LOW:   iv_low_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front end
	saane_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.nal_type   (nal_type),
		.unit_length(unit_length),
		.data_byte  (data_byte),
		.cmd_push   (cmd_push),
		.cmd        (push_cmd),
		.cmd_full   (cmd_full)
	);

	// command queue
	saane_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (push_cmd),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.not_empty(cmd_valid),
		.head     (head_cmd)
	);

	// back end
	saane_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (head_cmd),
		.cmd_pop      (cmd_pop),
		.key          ({key_high_q, key_low_q}),
		.iv           ({iv_high_q, iv_low_q}),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.is_prevention(is_prevention),
		.last_of_run  (last_of_run)
	);

endmodule

// ===== tb/sv/sample_aes_avc_nal_encryptor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_aes_avc_nal_encryptor_test
// Self-checking testbench for the NAL unit encryptor. A directed table covers
// raw units, the length threshold and zero runs that need prevention bytes;
// directed units cross block boundaries, random units follow. Every output
// byte is compared with a predictor that runs its own AES-128-CBC and escaping.
// ----------------------------------------------------------------------------
module sample_aes_avc_nal_encryptor_test;

	localparam int OFS_W = 32;
	localparam logic [OFS_W-1:0] NO_BLOCK = '1;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [7:0] value;
		logic       prevention;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic        action;
		logic [4:0]  utype;
		logic [31:0] ulen;
		logic [7:0]  dbyte;
	} in_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = 1'b0;
	logic [4:0]  nal_type = '0;
	logic [31:0] unit_length = '0;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        is_prevention;
	logic        last_of_run;

	sample_aes_avc_nal_encryptor dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [63:0]      m_key_hi, m_key_lo, m_iv_hi, m_iv_lo;
	logic             m_enc;
	logic [OFS_W-1:0] m_ofs, m_next_blk, m_blk_limit;
	logic [1:0]       m_zeros;
	logic [127:0]     m_chain;
	logic [7:0]       m_gather [16];
	int               m_fill;

	out_item_t expected_bytes [$];
	int  errors = 0;
	int  n_results = 0;
	int  n_blocks = 0;
	int  n_prev = 0;
	longint cycles = 0;
	bit  rx_calm = 0;
	bit  tx_calm = 0;
	bit  rx_hold = 0;

	// AES helpers written from the field arithmetic
	function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
		logic [7:0] p;
		p = 8'd0;
		for (int i = 0; i < 8; i++) begin
			if (b[0]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			b = b >> 1;
		end
		return p;
	endfunction

	function automatic logic [7:0] sbox_calc(logic [7:0] x);
		logic [7:0] r, base;
		int e;
		r = 8'd1;
		base = x;
		e = 254;
		while (e != 0) begin
			if (e[0]) r = gmul(r, base);
			base = gmul(base, base);
			e = e >> 1;
		end
		return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
			^ {r[3:0], r[7:4]} ^ 8'h63;
	endfunction

	function automatic logic [127:0] cipher_block(logic [127:0] blk, logic [127:0] key);
		logic [7:0] rk [176];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] w [4];
		logic [7:0] f, rc, a0, a1, a2, a3;
		logic [127:0] r;
		rc = 8'd1;
		for (int i = 0; i < 16; i++) rk[i] = key[127 - 8 * i -: 8];
		for (int i = 4; i < 44; i++) begin
			for (int j = 0; j < 4; j++) w[j] = rk[(i - 1) * 4 + j];
			if (i % 4 == 0) begin
				f = w[0];
				w[0] = sbox_calc(w[1]) ^ rc;
				w[1] = sbox_calc(w[2]);
				w[2] = sbox_calc(w[3]);
				w[3] = sbox_calc(f);
				rc = gmul(rc, 8'd2);
			end
			for (int j = 0; j < 4; j++) rk[i * 4 + j] = rk[(i - 4) * 4 + j] ^ w[j];
		end
		for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8] ^ rk[i];
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int i = 0; i < 16; i++) s[i] = sbox_calc(s[i]);
			for (int c = 0; c < 4; c++)
				for (int j = 0; j < 4; j++) t[j + 4 * c] = s[j + 4 * ((c + j) % 4)];
			if (rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4 * c];
					a1 = t[4 * c + 1];
					a2 = t[4 * c + 2];
					a3 = t[4 * c + 3];
					t[4 * c]     = gmul(a0, 8'd2) ^ gmul(a1, 8'd3) ^ a2 ^ a3;
					t[4 * c + 1] = a0 ^ gmul(a1, 8'd2) ^ gmul(a2, 8'd3) ^ a3;
					t[4 * c + 2] = a0 ^ a1 ^ gmul(a2, 8'd2) ^ gmul(a3, 8'd3);
					t[4 * c + 3] = gmul(a0, 8'd3) ^ a1 ^ a2 ^ gmul(a3, 8'd2);
				end
			end
			for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[rnd * 16 + i];
		end
		for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = s[i];
		return r;
	endfunction

	// escaped byte into a local list, updating the zero run
	function automatic void push_escaped(logic [7:0] b, ref out_item_t lst [$]);
		if (m_zeros < 2) begin
			m_zeros = (b == 0) ? m_zeros + 2'd1 : 2'd0;
		end else begin
			if (b[7:2] == 0) lst.push_back('{saane_pkg::PREVENTION_BYTE, 1'b1, 1'b0});
			m_zeros = (b == 0) ? 2'd1 : 2'd0;
		end
		lst.push_back('{b, 1'b0, 1'b0});
	endfunction

	// predicted output of one accepted transaction
	function automatic void predict_unit_bytes(in_item_t it);
		out_item_t lst [$];
		logic [127:0] c;
		logic [32:0] nxt;
		if (!it.action) begin
			m_fill = 0;
			m_zeros = 0;
			if ((it.utype != saane_pkg::TYPE_SLICE && it.utype != saane_pkg::TYPE_IDR)
				|| it.ulen <= 32'(saane_pkg::MIN_ENC_LEN))
				m_enc = 0;
			else begin
				m_enc = 1;
				m_ofs = 0;
				m_next_blk = OFS_W'(saane_pkg::FIRST_BLOCK);
				m_blk_limit = it.ulen - 32'(saane_pkg::BLOCK_BYTES);
				m_chain = {m_iv_hi, m_iv_lo};
			end
			return;
		end
		if (!m_enc) lst.push_back('{it.dbyte, 1'b0, 1'b0});
		else if (m_next_blk == NO_BLOCK || m_ofs < m_next_blk) push_escaped(it.dbyte, lst);
		else begin
			m_gather[m_fill] = it.dbyte;
			m_fill++;
			if (m_fill == 16) begin
				m_fill = 0;
				for (int i = 0; i < 16; i++) c[127 - 8 * i -: 8] = m_gather[i];
				c = cipher_block(c ^ m_chain, {m_key_hi, m_key_lo});
				m_chain = c;
				n_blocks++;
				for (int i = 0; i < 16; i++) push_escaped(c[127 - 8 * i -: 8], lst);
				nxt = {1'b0, m_next_blk} + 33'd160;
				m_next_blk = (nxt >= {1'b0, m_blk_limit}) ? NO_BLOCK : nxt[OFS_W-1:0];
			end
		end
		if (m_enc && m_ofs != NO_BLOCK) m_ofs++;
		if (lst.size() > 0) lst[lst.size() - 1].last = 1'b1;
		foreach (lst[i]) expected_bytes.push_back(lst[i]);
	endfunction

	// one register write; the caller drops the write enable afterwards
	task automatic write_reg(saane_pkg::cfg_idx_t idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			saane_pkg::REG_KEY_HIGH: m_key_hi = val;
			saane_pkg::REG_KEY_LOW:  m_key_lo = val;
			saane_pkg::REG_IV_HIGH:  m_iv_hi = val;
			default:                 m_iv_lo = val;
		endcase
	endtask

	task automatic wait_drained();
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// one transaction, with optional idle burst ahead of it
	task automatic send_item(in_item_t it);
		if (!tx_calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= it.action;
		nal_type <= it.utype;
		unit_length <= it.ulen;
		data_byte <= it.dbyte;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_unit_bytes(it);
	endtask

	task automatic send_unit(logic [4:0] ty, logic [31:0] len, int nbytes, int zero_pct);
		send_item('{1'b0, ty, len, 8'($urandom())});
		for (int i = 0; i < nbytes; i++)
			send_item('{1'b1, 5'($urandom()), 32'($urandom()),
				($urandom_range(1, 100) <= zero_pct) ? 8'h00 : 8'($urandom_range(0, 255))});
	endtask

	// receiver: compare every accepted output transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected output byte %h", $time, out_byte);
					errors++;
				end else begin
					out_item_t e;
					e = expected_bytes.pop_front();
					if (e.value !== out_byte || e.prevention !== is_prevention
						|| e.last !== last_of_run) begin
						$display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
							e.value, e.prevention, e.last, out_byte, is_prevention, last_of_run);
						errors++;
					end
					if (e.prevention) n_prev++;
					n_results++;
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (rx_hold) begin
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
				rx_hold = 0;
			end
			if (!rx_calm && $urandom_range(0, 6) == 0) begin
				gap = $urandom_range(1, 14);
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d bytes outstanding", expected_bytes.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// directed rows: kind, type, length, byte, expected byte (raw rows only)
	in_item_t  dir_in  [20];
	logic [8:0] dir_out [20];

	initial begin
		int sent;
		m_enc = 0; m_ofs = 0; m_next_blk = 0; m_blk_limit = 0; m_zeros = 0;
		m_chain = 0; m_fill = 0;
		m_key_hi = 0; m_key_lo = 0; m_iv_hi = 0; m_iv_lo = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// raw units: non-slice type, short slice at the threshold, byte extremes
		dir_in[0] = '{1'b0, 5'd31, 32'hffff_ffff, 8'h00}; dir_out[0] = 9'h100;
		dir_in[1] = '{1'b1, 5'd0, 32'd0, 8'h00};          dir_out[1] = 9'h000;
		dir_in[2] = '{1'b1, 5'd0, 32'd0, 8'h00};          dir_out[2] = 9'h000;
		dir_in[3] = '{1'b1, 5'd0, 32'd0, 8'h01};          dir_out[3] = 9'h001;
		dir_in[4] = '{1'b1, 5'd31, 32'hffff_ffff, 8'hff}; dir_out[4] = 9'h0ff;
		dir_in[5] = '{1'b0, saane_pkg::TYPE_SLICE, 32'd48, 8'hff}; dir_out[5] = 9'h100;
		dir_in[6] = '{1'b1, 5'd0, 32'd0, 8'h00};          dir_out[6] = 9'h000;
		dir_in[7] = '{1'b1, 5'd0, 32'd0, 8'h00};          dir_out[7] = 9'h000;
		dir_in[8] = '{1'b1, 5'd0, 32'd0, 8'h03};          dir_out[8] = 9'h003;
		dir_in[9] = '{1'b0, 5'd0, 32'd1000, 8'h00};       dir_out[9] = 9'h100;
		dir_in[10] = '{1'b1, 5'd2, 32'd0, 8'haa};         dir_out[10] = 9'h0aa;
		// encrypted unit, escaping on plain bytes: 00 00 03, 00 00 00, 00 00 04
		dir_in[11] = '{1'b0, saane_pkg::TYPE_IDR, 32'd49, 8'h00}; dir_out[11] = 9'h100;
		dir_in[12] = '{1'b1, 5'd0, 32'd0, 8'h00};         dir_out[12] = 9'h1ff;
		dir_in[13] = '{1'b1, 5'd0, 32'd0, 8'h00};         dir_out[13] = 9'h1ff;
		dir_in[14] = '{1'b1, 5'd0, 32'd0, 8'h03};         dir_out[14] = 9'h1ff;
		dir_in[15] = '{1'b1, 5'd0, 32'd0, 8'h00};         dir_out[15] = 9'h1ff;
		dir_in[16] = '{1'b1, 5'd0, 32'd0, 8'h00};         dir_out[16] = 9'h1ff;
		dir_in[17] = '{1'b1, 5'd0, 32'd0, 8'h00};         dir_out[17] = 9'h1ff;
		dir_in[18] = '{1'b1, 5'd0, 32'd0, 8'h00};         dir_out[18] = 9'h1ff;
		dir_in[19] = '{1'b1, 5'd0, 32'd0, 8'h04};         dir_out[19] = 9'h1ff;

		// typed-in rows are sent to the design; on raw rows the predictor must agree
		for (int i = 0; i < 20; i++) begin
			send_item(dir_in[i]);
			if (dir_out[i] < 9'h100) begin
				out_item_t e;
				e = expected_bytes[expected_bytes.size() - 1];
				if (e.value !== dir_out[i][7:0] || e.prevention || !e.last) begin
					$display("%0t: table row %0d expected %h actual %h", $time, i,
						dir_out[i][7:0], e.value);
					errors++;
				end
			end
		end
		// zero key and IV: a block dropped part way, then two encrypted blocks
		send_unit(saane_pkg::TYPE_IDR, 32'd49, 36, 50);
		send_unit(saane_pkg::TYPE_SLICE, 32'd209, 209, 30);
		in_valid <= 1'b0;
		wait_drained();

		// configuration phases: all ones, then random with a long hold, then calm
		for (int ph = 0; ph < 3; ph++) begin
			logic [63:0] v;
			for (int r = 0; r < 4; r++) begin
				v = (ph == 0) ? '1 : {$urandom(), $urandom()};
				write_reg(saane_pkg::cfg_idx_t'(r), v);
			end
			cfg_we <= 1'b0;
			sent = 0;
			if (ph == 1) rx_hold = 1;
			while (sent < 30) begin
				int kind, len, nb;
				kind = $urandom_range(0, 9);
				if (kind < 7) begin
					len = $urandom_range(49, 64);
					nb = (kind == 0) ? $urandom_range(0, len + 20) : len;
					send_unit(($urandom_range(0, 1) == 1) ? saane_pkg::TYPE_SLICE
						: saane_pkg::TYPE_IDR, len, nb, $urandom_range(0, 60));
				end else begin
					len = $urandom();
					nb = $urandom_range(0, 20);
					send_unit(5'($urandom()), (kind == 9) ? 32'($urandom_range(0, 48)) : len,
						nb, 30);
				end
				sent += nb + 1;
				if (ph == 2) begin
					rx_calm = 1;
					tx_calm = 1;
				end
			end
			// sender pauses until everything is back
			in_valid <= 1'b0;
			wait_drained();
		end

		$display("covered %0d output bytes, %0d cipher blocks, %0d prevention bytes",
			n_results, n_blocks, n_prev);
		if (errors == 0 && expected_bytes.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/saane_pkg.sv
rtl/saane_front.sv
rtl/saane_queue.sv
rtl/saane_back.sv
rtl/sample_aes_avc_nal_encryptor.sv
tb/sv/sample_aes_avc_nal_encryptor_test.sv
